/* hw/rtl/atsum_pkg.sv */
// package for the atanh series partial sum block
// word types, constants and sequencer states; no dependencies
package atsum_pkg;
    localparam int FracBits = 62;
    localparam int TermBits = 24;
    localparam int OutBits  = 63;
    localparam int DivBits  = TermBits + 2;
    localparam int SumBits  = FracBits + TermBits + 1;
    localparam int PcntBits = 6;
    localparam int DcntBits = 6;

    typedef struct packed {
        logic [FracBits-1:0]   z_value;
        logic [TermBits-1:0]   first_term;
        logic [TermBits:0]     end_term;
    } t_in_word;

    typedef struct packed {
        logic [OutBits-1:0] doubled_sum;
        logic               saturated;
    } t_out_word;

    typedef enum logic [3:0] {
        ST_IDLE, ST_ZZ, ST_PCHK, ST_PMUL_R, ST_PMUL_B, ST_PZ,
        ST_TERM, ST_DIV, ST_STEP, ST_DONE
    } t_state;

    typedef struct packed {
        logic                start;
        logic [FracBits-1:0] a;
        logic [FracBits-1:0] b;
    } t_mul_req;
endpackage

/* hw/rtl/atanh_series_partial_sum.sv */
// atanh series partial sum: sequencer around a shared multiplier and divider
// z*z, (z*z)^first_term by square-and-multiply, times z, then per term a divide and step
// an empty range skips the arithmetic; words are taken only when idle, one at a time
// power loop ends at a zero exponent or power, term loop at end_term or at zero power
// reset (i_rst_n low, synchronous) returns the sequencer to idle and drops o_valid
// depends on atsum_pkg, atsum_mul, atsum_div
module atanh_series_partial_sum (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  atsum_pkg::t_in_word  i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output atsum_pkg::t_out_word o_data
);
    import atsum_pkg::*;

    t_state r_state, n_state;
    logic [FracBits-1:0] r_z, r_zz, r_r, r_b, r_p;
    logic                r_one;
    logic [TermBits-1:0] r_e;
    logic [TermBits:0]   r_n;
    logic [TermBits:0]   r_end;
    logic [SumBits-1:0]  r_sum;
    t_mul_req w_req;
    logic w_mdone, w_dstart, w_ddone;
    logic [FracBits-1:0] w_prod, w_quo;
    logic [DivBits-1:0]  w_den;
    logic [SumBits:0]    w_dbl;

    atsum_mul u_mul (.i_clk, .i_rst_n, .i_req(w_req), .o_done(w_mdone), .o_prod(w_prod));
    atsum_div u_div (.i_clk, .i_rst_n, .i_start(w_dstart), .i_num(r_p), .i_den(w_den),
                     .o_done(w_ddone), .o_quo(w_quo));

    assign w_den   = {r_n, 1'b1};
    assign o_stall = (r_state != ST_IDLE);
    assign w_dbl   = {r_sum, 1'b0};

    always_comb begin
        n_state  = r_state;
        w_req    = '0;
        w_dstart = 1'b0;
        unique case (r_state)
            ST_IDLE: if (i_valid) begin
                if (i_data.end_term > {1'b0, i_data.first_term}) begin
                    w_req = '{start: 1'b1, a: i_data.z_value, b: i_data.z_value};
                    n_state = ST_ZZ;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_ZZ: if (w_mdone) n_state = ST_PCHK;
            ST_PCHK: begin
                if (r_e == '0 || (!r_one && r_r == '0)) begin
                    if (r_one) begin
                        n_state = ST_TERM;
                    end else begin
                        w_req = '{start: 1'b1, a: r_r, b: r_z};
                        n_state = ST_PZ;
                    end
                end else if (r_e[0]) begin
                    if (r_one) begin
                        w_req = '{start: 1'b1, a: r_b, b: r_b};
                        n_state = ST_PMUL_B;
                    end else begin
                        w_req = '{start: 1'b1, a: r_r, b: r_b};
                        n_state = ST_PMUL_R;
                    end
                end else begin
                    w_req = '{start: 1'b1, a: r_b, b: r_b};
                    n_state = ST_PMUL_B;
                end
            end
            ST_PMUL_R: if (w_mdone) begin
                w_req = '{start: 1'b1, a: r_b, b: r_b};
                n_state = ST_PMUL_B;
            end
            ST_PMUL_B: if (w_mdone) n_state = ST_PCHK;
            ST_PZ: if (w_mdone) n_state = ST_TERM;
            ST_TERM: begin
                if (r_n >= r_end || r_p == '0) begin
                    n_state = ST_DONE;
                end else begin
                    w_dstart = 1'b1;
                    w_req = '{start: 1'b1, a: r_p, b: r_zz};
                    n_state = ST_DIV;
                end
            end
            ST_DIV: if (w_ddone) n_state = ST_STEP;
            ST_STEP: n_state = ST_TERM;
            ST_DONE: if (!o_valid || !i_stall) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_valid && !i_stall) o_valid <= 1'b0;
            if (r_state == ST_DONE && (!o_valid || !i_stall)) begin
                o_valid <= 1'b1;
                if (w_dbl[SumBits:OutBits+FracBits-58] != '0) begin
                    o_data.doubled_sum <= {OutBits{1'b1}};
                    o_data.saturated   <= 1'b1;
                end else begin
                    // q25.62 sum doubled to q5.58: drop four more bits
                    o_data.doubled_sum <= OutBits'(w_dbl >> (FracBits - 58));
                    o_data.saturated   <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: if (i_valid) begin
                r_z   <= i_data.z_value;
                r_e   <= i_data.first_term;
                r_n   <= {1'b0, i_data.first_term};
                r_end <= i_data.end_term;
                r_sum <= '0;
                r_r   <= '0;
                r_one <= 1'b1;
                r_p   <= '0;
            end
            ST_ZZ: if (w_mdone) begin
                r_zz <= w_prod;
                r_b  <= w_prod;
            end
            // power still 1.0: p is z itself, or the first set bit just takes b
            ST_PCHK: if (r_one) begin
                if (r_e == '0) begin
                    r_p <= r_z;
                end else if (r_e[0]) begin
                    r_r   <= r_b;
                    r_one <= 1'b0;
                end
            end
            ST_PMUL_R: if (w_mdone) r_r <= w_prod;
            ST_PMUL_B: if (w_mdone) begin
                r_b <= w_prod;
                r_e <= r_e >> 1;
            end
            ST_PZ: if (w_mdone) r_p <= w_prod;
            ST_DIV: if (w_ddone) r_sum <= r_sum + SumBits'(w_quo);
            ST_STEP: begin
                r_p <= w_prod;
                r_n <= r_n + (TermBits+1)'(1);
            end
            default: ;
        endcase
    end
endmodule

/* hw/rtl/atsum_mul.sv */
// shared q0.62 multiplier, 32x32 partial products one per cycle
// depends on atsum_pkg
module atsum_mul (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  atsum_pkg::t_mul_req          i_req,
    output logic                         o_done,
    output logic [atsum_pkg::FracBits-1:0] o_prod
);
    import atsum_pkg::*;

    logic [31:0]  r_a0, r_a1, r_b0, r_b1;
    logic [127:0] r_acc;
    logic [2:0]   r_cnt;
    logic         r_busy;
    logic [31:0]  w_x, w_y;
    logic [63:0]  w_pp;
    logic [127:0] w_sh;

    always_comb begin
        case (r_cnt[1:0])
            2'd0: begin w_x = r_a0; w_y = r_b0; w_sh = 128'(w_pp); end
            2'd1: begin w_x = r_a0; w_y = r_b1; w_sh = 128'(w_pp) << 32; end
            2'd2: begin w_x = r_a1; w_y = r_b0; w_sh = 128'(w_pp) << 32; end
            default: begin w_x = r_a1; w_y = r_b1; w_sh = 128'(w_pp) << 64; end
        endcase
    end
    assign w_pp = 64'(w_x) * 64'(w_y);

    always_ff @(posedge i_clk) begin
        o_done <= 1'b0;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_a0  <= i_req.a[31:0];
            r_a1  <= 32'(i_req.a[FracBits-1:32]);
            r_b0  <= i_req.b[31:0];
            r_b1  <= 32'(i_req.b[FracBits-1:32]);
            r_acc <= '0;
            r_cnt <= '0;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            r_acc <= r_acc + w_sh;
            r_cnt <= r_cnt + 3'd1;
            if (r_cnt == 3'd3) begin
                r_busy <= 1'b0;
                o_done <= 1'b1;
            end
        end
    end
    always_comb o_prod = r_acc[FracBits +: FracBits];
    // result taken from accumulator once done
endmodule

/* hw/rtl/atsum_div.sv */
// restoring divider, one quotient bit per cycle
// depends on atsum_pkg
module atsum_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [atsum_pkg::FracBits-1:0] i_num,
    input  logic [atsum_pkg::DivBits-1:0]  i_den,
    output logic                          o_done,
    output logic [atsum_pkg::FracBits-1:0] o_quo
);
    import atsum_pkg::*;

    logic [FracBits-1:0] r_q;
    logic [DivBits:0]    r_rem;
    logic [DivBits-1:0]  r_den;
    logic [DcntBits-1:0] r_cnt;
    logic                r_busy;
    logic [DivBits:0]    w_trial;

    assign w_trial = {r_rem[DivBits-1:0], r_q[FracBits-1]};

    always_ff @(posedge i_clk) begin
        o_done <= 1'b0;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_q    <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
            r_cnt  <= '0;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_den}) begin
                r_rem <= w_trial - {1'b0, r_den};
                r_q   <= {r_q[FracBits-2:0], 1'b1};
            end else begin
                r_rem <= w_trial;
                r_q   <= {r_q[FracBits-2:0], 1'b0};
            end
            r_cnt <= r_cnt + DcntBits'(1);
            if (r_cnt == DcntBits'(FracBits - 1)) begin
                r_busy <= 1'b0;
                o_done <= 1'b1;
            end
        end
    end
    assign o_quo = r_q;
endmodule
